[src/hcls_pkg.sv]
// Shared types, widths and register codes for the height-cell Lambert shader.
// Used by the channel interfaces and by every module of the block.
package hcls_pkg;

  localparam int unsigned COORD_W    = 12;
  localparam int unsigned H_W        = 16;
  localparam int unsigned MAG_W      = 16;
  localparam int unsigned GZ_W       = 13;
  localparam int unsigned SUM_W      = 34;
  localparam int unsigned ROOT_W     = 17;
  localparam int unsigned REM_W      = 19;
  localparam int unsigned NUM_W      = 25;
  localparam int unsigned Q_W        = 10;
  localparam int unsigned LIGHT_W    = 10;
  localparam int unsigned PROD_W     = 21;
  localparam int unsigned INT_W      = 9;
  localparam int unsigned GREY_W     = 4;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned SQRT_CELLS = 17;
  localparam int unsigned DIV_CELLS  = 10;
  localparam int unsigned SCALE_SH   = 9;

  localparam logic [INT_W-1:0] MAX_INTENSITY = 9'd511;

  localparam logic signed [LIGHT_W-1:0] LIGHT_X_RST = -10'sd50;
  localparam logic signed [LIGHT_W-1:0] LIGHT_Y_RST = 10'sd360;
  localparam logic signed [LIGHT_W-1:0] LIGHT_Z_RST = 10'sd360;

  typedef enum logic [IDX_W-1:0] {
    REG_SHADE_ENABLE = 8'd0,
    REG_LIGHT_X      = 8'd1,
    REG_LIGHT_Y      = 8'd2,
    REG_LIGHT_Z      = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                      shade_enable;
    logic signed [LIGHT_W-1:0] light_x;
    logic signed [LIGHT_W-1:0] light_y;
    logic signed [LIGHT_W-1:0] light_z;
  } cfg_t;

  // Gradient magnitudes and signs; z is never negative.
  typedef struct packed {
    logic [MAG_W-1:0] mx;
    logic [MAG_W-1:0] my;
    logic [GZ_W-1:0]  mz;
    logic             sx;
    logic             sy;
  } grad_t;

  typedef struct packed {
    logic [SUM_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    grad_t             g;
  } sqrt_pl_t;

  typedef struct packed {
    logic [NUM_W-1:0]  nx;
    logic [NUM_W-1:0]  ny;
    logic [NUM_W-1:0]  nz;
    logic [ROOT_W-1:0] d;
    logic [Q_W-1:0]    qx;
    logic [Q_W-1:0]    qy;
    logic [Q_W-1:0]    qz;
    logic              sx;
    logic              sy;
  } div_pl_t;

endpackage

[src/hcls_if.sv]
// Valid/ready channel interfaces of the height-cell Lambert shader.
// Depends on hcls_pkg for field widths.
interface hcls_in_if;
  logic                                valid;
  logic                                ready;
  logic        [hcls_pkg::COORD_W-1:0] col;
  logic        [hcls_pkg::COORD_W-1:0] row;
  logic signed [hcls_pkg::H_W-1:0]     h_here;
  logic signed [hcls_pkg::H_W-1:0]     h_right;
  logic signed [hcls_pkg::H_W-1:0]     h_below;
  logic signed [hcls_pkg::H_W-1:0]     h_diag;
  modport source (output valid, col, row, h_here, h_right, h_below, h_diag, input ready);
  modport sink (input valid, col, row, h_here, h_right, h_below, h_diag, output ready);
endinterface

interface hcls_out_if;
  logic                         valid;
  logic                         ready;
  logic [hcls_pkg::INT_W-1:0]   intensity;
  logic [hcls_pkg::GREY_W-1:0]  grey_level;
  modport source (output valid, intensity, grey_level, input ready);
  modport sink (input valid, intensity, grey_level, output ready);
endinterface

interface hcls_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [hcls_pkg::IDX_W-1:0]        index;
  logic [hcls_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/height_cell_lambert_shade.sv]
// Lambert shading of height-field cells: top level, configuration registers and cell chain.
// Depends on hcls_pkg, the channel interfaces, hcls_front, the cells and hcls_back.
//
// One cell enters per clock and one result leaves per clock for as long as the result side
// takes them; there is no dependence between cells. The chain has three front stages,
// seventeen square-root cells (one root bit each), ten divider cells (one quotient bit each
// for all three components) and two back stages, the last being the output register. Each
// stage holds while the stage after it is full and stalled, so empty stages keep filling
// behind a stalled output. Configuration writes take effect at once and are meant only while
// no cell is in flight.
module height_cell_lambert_shade (
  input  logic        clk,
  input  logic        rst_n,
  hcls_in_if.sink     in_ch,
  hcls_out_if.source  out_ch,
  hcls_cfg_if.sink    cfg_ch
);
  import hcls_pkg::*;

  cfg_t cfg_r;

  logic     sv  [0:SQRT_CELLS];
  sqrt_pl_t sd  [0:SQRT_CELLS];
  logic     sen [0:SQRT_CELLS];
  logic     dv  [0:DIV_CELLS];
  div_pl_t  dd  [0:DIV_CELLS];
  logic     den [0:DIV_CELLS];
  grad_t    gl;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shade_enable <= 1'b0;
      cfg_r.light_x      <= LIGHT_X_RST;
      cfg_r.light_y      <= LIGHT_Y_RST;
      cfg_r.light_z      <= LIGHT_Z_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_SHADE_ENABLE: cfg_r.shade_enable <= cfg_ch.data[0];
        REG_LIGHT_X:      cfg_r.light_x      <= $signed(cfg_ch.data);
        REG_LIGHT_Y:      cfg_r.light_y      <= $signed(cfg_ch.data);
        REG_LIGHT_Z:      cfg_r.light_z      <= $signed(cfg_ch.data);
        default: ;
      endcase
    end
  end

  hcls_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .dn_en   (sen[0]),
    .valid_o (sv[0]),
    .data_o  (sd[0])
  );

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    hcls_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (sv[i]),
      .up_data  (sd[i]),
      .dn_en    (sen[i+1]),
      .en       (sen[i]),
      .valid_r  (sv[i+1]),
      .data_r   (sd[i+1])
    );
  end

  // Hand the root and the scaled magnitudes to the divider; a zero root becomes one.
  assign gl          = sd[SQRT_CELLS].g;
  assign sen[SQRT_CELLS] = den[0];
  assign dv[0]       = sv[SQRT_CELLS];
  assign dd[0].nx    = {gl.mx, {SCALE_SH{1'b0}}};
  assign dd[0].ny    = {gl.my, {SCALE_SH{1'b0}}};
  assign dd[0].nz    = NUM_W'({gl.mz, {SCALE_SH{1'b0}}});
  assign dd[0].d     = (sd[SQRT_CELLS].root == '0) ? ROOT_W'(1) : sd[SQRT_CELLS].root;
  assign dd[0].qx    = '0;
  assign dd[0].qy    = '0;
  assign dd[0].qz    = '0;
  assign dd[0].sx    = gl.sx;
  assign dd[0].sy    = gl.sy;

  for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
    hcls_div_cell #(
      .BIT (DIV_CELLS - 1 - j)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (dv[j]),
      .up_data  (dd[j]),
      .dn_en    (den[j+1]),
      .en       (den[j]),
      .valid_r  (dv[j+1]),
      .data_r   (dd[j+1])
    );
  end

  hcls_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (dv[DIV_CELLS]),
    .up_data  (dd[DIV_CELLS]),
    .cfg      (cfg_r),
    .en       (den[DIV_CELLS]),
    .out_ch   (out_ch)
  );

  a_grey_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.grey_level == out_ch.intensity[INT_W-1 -: GREY_W])
    else $error("grey level does not follow intensity");

  a_unshaded_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !cfg_r.shade_enable |-> out_ch.intensity == MAX_INTENSITY)
    else $error("shading off but intensity not full");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  a_drain_opens_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready |-> in_ch.ready)
    else $error("input blocked while the chain advances");

endmodule

[src/hcls_front.sv]
// Front cells: corner differences, squares and sum of squares, three stages.
// Depends on hcls_pkg and hcls_in_if.
module hcls_front (
  input  logic              clk,
  input  logic              rst_n,
  hcls_in_if.sink           in_ch,
  input  logic              dn_en,
  output logic              valid_o,
  output hcls_pkg::sqrt_pl_t data_o
);
  import hcls_pkg::*;

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;
  grad_t g1_r, g2_r, g3_r;
  grad_t g1_nxt;
  logic [2*MAG_W-1:0] sqx_r, sqy_r;
  logic [2*GZ_W-1:0]  sqz_r;
  logic [SUM_W-1:0]   sum_r;

  logic signed [H_W+1:0] dx, dy, hx, hy;

  assign en3 = !v3_r || dn_en;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ch.ready = en1;

  always_comb begin
    dx = (18'(in_ch.h_right) - 18'(in_ch.h_here)) + (18'(in_ch.h_diag) - 18'(in_ch.h_below));
    dy = (18'(in_ch.h_here) - 18'(in_ch.h_below)) + (18'(in_ch.h_right) - 18'(in_ch.h_diag));
    // halve, truncating toward zero
    hx = $signed(dx + 18'(dx[H_W+1])) >>> 1;
    hy = $signed(dy + 18'(dy[H_W+1])) >>> 1;
    g1_nxt.sx = hx[H_W+1];
    g1_nxt.sy = hy[H_W+1];
    g1_nxt.mx = hx[H_W+1] ? MAG_W'(-hx) : hx[MAG_W-1:0];
    g1_nxt.my = hy[H_W+1] ? MAG_W'(-hy) : hy[MAG_W-1:0];
    g1_nxt.mz = {1'b0, in_ch.col} + {1'b0, in_ch.row};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) g1_r <= g1_nxt;
    if (en2) begin
      g2_r  <= g1_r;
      sqx_r <= g1_r.mx * g1_r.mx;
      sqy_r <= g1_r.my * g1_r.my;
      sqz_r <= g1_r.mz * g1_r.mz;
    end
    if (en3) begin
      g3_r  <= g2_r;
      sum_r <= SUM_W'(sqx_r) + SUM_W'(sqy_r) + SUM_W'(sqz_r);
    end
  end

  assign valid_o     = v3_r;
  assign data_o.rad  = sum_r;
  assign data_o.rem  = '0;
  assign data_o.root = '0;
  assign data_o.g    = g3_r;

endmodule

[src/hcls_sqrt_cell.sv]
// One square-root cell: retires one root bit from two radicand bits.
// Depends on hcls_pkg.
module hcls_sqrt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  input  hcls_pkg::sqrt_pl_t up_data,
  input  logic               dn_en,
  output logic               en,
  output logic               valid_r,
  output hcls_pkg::sqrt_pl_t data_r
);
  import hcls_pkg::*;

  logic [REM_W+1:0] cur, trial;
  sqrt_pl_t data_nxt;

  assign en = !valid_r || dn_en;

  always_comb begin
    cur   = {up_data.rem, up_data.rad[SUM_W-1 -: 2]};
    trial = (REM_W+2)'({up_data.root, 2'b01});
    data_nxt     = up_data;
    data_nxt.rad = {up_data.rad[SUM_W-3:0], 2'b00};
    if (cur >= trial) begin
      data_nxt.rem  = REM_W'(cur - trial);
      data_nxt.root = {up_data.root[ROOT_W-2:0], 1'b1};
    end else begin
      data_nxt.rem  = cur[REM_W-1:0];
      data_nxt.root = {up_data.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) data_r <= data_nxt;
  end

endmodule

[src/hcls_div_cell.sv]
// One divider cell: decides quotient bit BIT for the three scaled components.
// Depends on hcls_pkg.
module hcls_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  input  hcls_pkg::div_pl_t up_data,
  input  logic              dn_en,
  output logic              en,
  output logic              valid_r,
  output hcls_pkg::div_pl_t data_r
);
  import hcls_pkg::*;

  localparam logic [Q_W-1:0] QBIT = Q_W'(1) << BIT;

  logic [NUM_W:0] dsh;
  div_pl_t data_nxt;

  assign en = !valid_r || dn_en;

  always_comb begin
    dsh      = (NUM_W+1)'(up_data.d) << BIT;
    data_nxt = up_data;
    if ({1'b0, up_data.nx} >= dsh) begin
      data_nxt.nx = NUM_W'({1'b0, up_data.nx} - dsh);
      data_nxt.qx = up_data.qx | QBIT;
    end
    if ({1'b0, up_data.ny} >= dsh) begin
      data_nxt.ny = NUM_W'({1'b0, up_data.ny} - dsh);
      data_nxt.qy = up_data.qy | QBIT;
    end
    if ({1'b0, up_data.nz} >= dsh) begin
      data_nxt.nz = NUM_W'({1'b0, up_data.nz} - dsh);
      data_nxt.qz = up_data.qz | QBIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) data_r <= data_nxt;
  end

endmodule

[src/hcls_back.sv]
// Back cells: light products, then sum, clamp and the output register.
// Depends on hcls_pkg and hcls_out_if.
module hcls_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  input  hcls_pkg::div_pl_t up_data,
  input  hcls_pkg::cfg_t    cfg,
  output logic              en,
  hcls_out_if.source        out_ch
);
  import hcls_pkg::*;

  logic pv_r, ov_r, en_f;
  logic signed [PROD_W-1:0] px_r, py_r, pz_r;
  logic signed [Q_W:0]      sx, sy, sz;
  logic signed [PROD_W-1:0] rx, ry, rz;
  logic signed [GREY_W+9:0] tot;
  logic [INT_W-1:0]         int_r, int_nxt;

  assign en_f = !ov_r || out_ch.ready;
  assign en   = !pv_r || en_f;

  always_comb begin
    sx = up_data.sx ? -$signed({1'b0, up_data.qx}) : $signed({1'b0, up_data.qx});
    sy = up_data.sy ? -$signed({1'b0, up_data.qy}) : $signed({1'b0, up_data.qy});
    sz = $signed({1'b0, up_data.qz});
  end

  always_comb begin
    // divide each product by 512, truncating toward zero
    rx  = $signed(px_r + (px_r[PROD_W-1] ? PROD_W'(511) : '0)) >>> SCALE_SH;
    ry  = $signed(py_r + (py_r[PROD_W-1] ? PROD_W'(511) : '0)) >>> SCALE_SH;
    rz  = $signed(pz_r + (pz_r[PROD_W-1] ? PROD_W'(511) : '0)) >>> SCALE_SH;
    tot = (GREY_W+10)'(rx) + (GREY_W+10)'(ry) + (GREY_W+10)'(rz);
    if (!cfg.shade_enable) begin
      int_nxt = MAX_INTENSITY;
    end else if (tot < 0) begin
      int_nxt = '0;
    end else if (tot > (GREY_W+10)'(MAX_INTENSITY)) begin
      int_nxt = MAX_INTENSITY;
    end else begin
      int_nxt = tot[INT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (en)   pv_r <= up_valid;
      if (en_f) ov_r <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= sx * cfg.light_x;
      py_r <= sy * cfg.light_y;
      pz_r <= sz * cfg.light_z;
    end
    if (en_f) int_r <= int_nxt;
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.intensity  = int_r;
  assign out_ch.grey_level = int_r[INT_W-1 -: GREY_W];

endmodule

[tb/sv/height_cell_lambert_shade_test.sv]
// Self-checking testbench for height_cell_lambert_shade: directed cells, then random cells,
// each checked against the expected values of a typed table row or else an in-file shading
// predictor. Depends on hcls_pkg and the channel interfaces hcls_in_if, hcls_out_if and hcls_cfg_if.
module height_cell_lambert_shade_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hcls_pkg::*;

  localparam logic [IDX_W-1:0] UNUSED_REG_IDX = 8'hA5;
  localparam int unsigned      DRAIN_CYCLES   = 40;
  localparam int unsigned      PHASE_CELLS    = 110;

  typedef struct {
    logic        [COORD_W-1:0] col;
    logic        [COORD_W-1:0] row;
    logic signed [H_W-1:0]     h_here;
    logic signed [H_W-1:0]     h_right;
    logic signed [H_W-1:0]     h_below;
    logic signed [H_W-1:0]     h_diag;
    bit                        typed;
    logic        [INT_W-1:0]   t_int;
    logic        [GREY_W-1:0]  t_grey;
  } cell_t;

  typedef struct {
    logic [INT_W-1:0]  intensity;
    logic [GREY_W-1:0] grey_level;
  } shade_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   failed = 1'b0;

  hcls_in_if  in_ch();
  hcls_out_if out_ch();
  hcls_cfg_if cfg_ch();

  height_cell_lambert_shade dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  always #4 clk = ~clk;

  // Predictor copy of the registers
  logic                      shading_on = 1'b0;
  logic signed [LIGHT_W-1:0] lx = LIGHT_X_RST;
  logic signed [LIGHT_W-1:0] ly = LIGHT_Y_RST;
  logic signed [LIGHT_W-1:0] lz = LIGHT_Z_RST;

  shade_t      pending_shades[$];
  int unsigned results_seen = 0;

  function automatic shade_t shade_cell(cell_t c);
    shade_t          s;
    longint          gx, gy, gz, len, sx, sy, sz, res;
    longint unsigned sum, root, trial;
    if (!shading_on) begin
      s.intensity = MAX_INTENSITY;
      s.grey_level = 4'd15;
      return s;
    end
    gx = ((longint'(c.h_right) - c.h_here) + (longint'(c.h_diag) - c.h_below)) / 2;
    gy = ((longint'(c.h_here) - c.h_below) + (longint'(c.h_right) - c.h_diag)) / 2;
    gz = longint'(c.col) + longint'(c.row);
    sum = gx * gx + gy * gy + gz * gz;
    root = 0;
    for (int b = 17; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sum) root = trial;
    end
    len = (root == 0) ? 1 : longint'(root);
    sx = (gx * 512) / len;
    sy = (gy * 512) / len;
    sz = (gz * 512) / len;
    res = (sx * longint'(lx)) / 512 + (sy * longint'(ly)) / 512 + (sz * longint'(lz)) / 512;
    if (res < 0) res = 0;
    if (res > 511) res = 511;
    s.intensity = res[INT_W-1:0];
    s.grey_level = GREY_W'(res / 32);
    return s;
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_SHADE_ENABLE: shading_on = val[0];
      REG_LIGHT_X:      lx = val;
      REG_LIGHT_Y:      ly = val;
      REG_LIGHT_Z:      lz = val;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (pending_shades.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  int unsigned gap_mode = 0;

  task automatic send_cell(cell_t c);
    shade_t      s;
    int unsigned gap;
    in_ch.valid   <= 1'b1;
    in_ch.col     <= c.col;
    in_ch.row     <= c.row;
    in_ch.h_here  <= c.h_here;
    in_ch.h_right <= c.h_right;
    in_ch.h_below <= c.h_below;
    in_ch.h_diag  <= c.h_diag;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    s = shade_cell(c);
    if (c.typed) begin
      s.intensity = c.t_int;
      s.grey_level = c.t_grey;
    end
    pending_shades.push_back(s);
    gap = 0;
    if (gap_mode != 0) begin
      gap = $urandom_range(0, 99);
      gap = (gap < 60) ? 0 : (gap < 95) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    end
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic cell_t rand_cell();
    cell_t       c;
    int unsigned m;
    logic signed [H_W-1:0] base;
    int          spread;
    m = $urandom_range(0, 9);
    c.typed = 1'b0;
    c.col = (m < 5) ? COORD_W'($urandom_range(0, 63)) : COORD_W'($urandom());
    c.row = (m < 5) ? COORD_W'($urandom_range(0, 63)) : COORD_W'($urandom());
    if (m < 3) begin
      c.h_here = H_W'($urandom()); c.h_right = H_W'($urandom());
      c.h_below = H_W'($urandom()); c.h_diag = H_W'($urandom());
    end else begin
      // gentle terrain: a base height with small corner offsets
      base = H_W'($urandom());
      spread = (m < 7) ? 16 : 600;
      c.h_here  = base;
      c.h_right = H_W'(base + $signed($urandom_range(0, 2 * spread)) - spread);
      c.h_below = H_W'(base + $signed($urandom_range(0, 2 * spread)) - spread);
      c.h_diag  = H_W'(base + $signed($urandom_range(0, 2 * spread)) - spread);
    end
    return c;
  endfunction

  cell_t off_rows[] = '{
    '{12'd0,    12'd0,    16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 9'd511, 4'd15},
    '{12'd4095, 12'd4095, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b1, 9'd511, 4'd15},
    '{12'd1,    12'd2,    16'sh8000, 16'sh7fff, 16'shffff, 16'sh0001, 1'b1, 9'd511, 4'd15}
  };

  cell_t on_rows[] = '{
    // zero length: all flat at the origin
    '{12'd0,    12'd0,    16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 9'd0,   4'd0},
    // flat cell: the normal is straight up, only light z counts
    '{12'd4095, 12'd4095, 16'sh1234, 16'sh1234, 16'sh1234, 16'sh1234, 1'b1, 9'd360, 4'd11},
    '{12'd5,    12'd0,    16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 9'd360, 4'd11},
    '{12'd0,    12'd0,    16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0, 9'd0,   4'd0},
    '{12'd0,    12'd0,    16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, 9'd0,   4'd0},
    '{12'd0,    12'd0,    16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 1'b0, 9'd0,   4'd0},
    '{12'd0,    12'd0,    16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 1'b0, 9'd0,   4'd0},
    '{12'd4095, 12'd0,    16'sh0000, 16'sh0001, 16'sh0000, 16'sh0000, 1'b0, 9'd0,   4'd0},
    '{12'd0,    12'd0,    16'sh0000, 16'sh0001, 16'sh0000, 16'sh0000, 1'b0, 9'd0,   4'd0},
    '{12'd3,    12'd7,    16'shfffd, 16'sh0003, 16'sh0002, 16'shfffe, 1'b0, 9'd0,   4'd0},
    '{12'd100,  12'd4095, 16'sh0010, 16'shfff0, 16'sh0020, 16'sh0000, 1'b0, 9'd0,   4'd0}
  };

  // Result side: random ready with one long hold-off once traffic is flowing
  initial begin
    int unsigned r, n;
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (!held && results_seen >= 300) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        n = 120;
      end else if (r < 60) begin
        out_ch.ready <= 1'b1;
        n = $urandom_range(1, 20);
      end else begin
        out_ch.ready <= 1'b0;
        n = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    shade_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen <= results_seen + 1;
      if (pending_shades.size() == 0) begin
        $error("unexpected transfer: intensity %0d grey_level %0d",
               out_ch.intensity, out_ch.grey_level);
        failed = 1'b1;
      end else begin
        e = pending_shades.pop_front();
        if (out_ch.intensity !== e.intensity) begin
          $error("intensity: expected %0d, actual %0d", e.intensity, out_ch.intensity);
          failed = 1'b1;
        end
        if (out_ch.grey_level !== e.grey_level) begin
          $error("grey_level: expected %0d, actual %0d", e.grey_level, out_ch.grey_level);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.col = '0;
    in_ch.row = '0;
    in_ch.h_here = '0;
    in_ch.h_right = '0;
    in_ch.h_below = '0;
    in_ch.h_diag = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_SHADE_ENABLE;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_mode = 1;
    foreach (off_rows[i]) send_cell(off_rows[i]);
    in_ch.valid <= 1'b0;
    wait_idle();
    write_reg(UNUSED_REG_IDX, 10'h3ff);
    write_reg(REG_SHADE_ENABLE, 10'd1);
    foreach (on_rows[i]) send_cell(on_rows[i]);
    in_ch.valid <= 1'b0;
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: ;
        1: begin
          write_reg(REG_LIGHT_X, 10'h200);
          write_reg(REG_LIGHT_Y, 10'h200);
          write_reg(REG_LIGHT_Z, 10'h200);
        end
        2: begin
          write_reg(REG_LIGHT_X, 10'h1ff);
          write_reg(REG_LIGHT_Y, 10'h1ff);
          write_reg(REG_LIGHT_Z, 10'h1ff);
        end
        3: write_reg(REG_SHADE_ENABLE, 10'd0);
        default: begin
          write_reg(REG_SHADE_ENABLE, 10'd1);
          write_reg(REG_LIGHT_X, CFG_DATA_W'($urandom()));
          write_reg(REG_LIGHT_Y, CFG_DATA_W'($urandom()));
          write_reg(REG_LIGHT_Z, CFG_DATA_W'($urandom()));
        end
      endcase
      // odd phases run back to back with no input gaps
      gap_mode = ph % 2 == 0;
      repeat (PHASE_CELLS) send_cell(rand_cell());
      in_ch.valid <= 1'b0;
      wait_idle();
    end

    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
